>>> design/gsp_pkg.sv
// shared types, codes and constants of the gamepad poll engine
`default_nettype none
package gsp_pkg;

	localparam int DEF_MAX_PAIRS = 16;
	localparam logic [7:0] TIMEOUT_RESET = 8'h50;

	// result queue depth and the most results one input word can cause
	localparam int RES_DEPTH = 8;
	localparam int RES_MAX = 3;

	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_BYTE  = 2'd1;
	localparam logic [1:0] MODE_ACK   = 2'd2;
	localparam logic [1:0] MODE_TICK  = 2'd3;

	localparam logic [1:0] ACT_SEND   = 2'd0;
	localparam logic [1:0] ACT_STORE  = 2'd1;
	localparam logic [1:0] ACT_DONE   = 2'd2;
	localparam logic [1:0] ACT_ABORT  = 2'd3;

	localparam logic [7:0] BYTE_HDR    = 8'h01;
	localparam logic [7:0] BYTE_ID_REQ = 8'h42;
	localparam logic [7:0] BYTE_IDLE   = 8'h00;
	localparam logic [7:0] BYTE_CHK    = 8'h5a;
	localparam logic [7:0] BYTE_BUSY   = 8'hff;
	localparam logic [3:0] NIBBLE_MASK = 4'hf;

	localparam logic [5:0] IDX_STATUS = 6'd0;
	localparam logic [5:0] IDX_ID     = 6'd1;
	localparam logic [5:0] IDX_FIRST  = 6'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic       port;
		logic [7:0] rx_byte;
	} in_word_t;

	typedef struct packed {
		logic [1:0] action;
		logic       sel_port;
		logic [5:0] buf_index;
		logic [7:0] data_byte;
		logic       last;
	} out_word_t;

	typedef struct packed {
		logic [1:0]                cnt;
		out_word_t [RES_MAX-1:0]   word;
	} res_bundle_t;

	typedef enum logic [9:0] {
		PH_IDLE    = 10'b0000000001,
		PH_RX_HDR  = 10'b0000000010,
		PH_ACK_HDR = 10'b0000000100,
		PH_RX_ID   = 10'b0000001000,
		PH_ACK_ID  = 10'b0000010000,
		PH_RX_CHK  = 10'b0000100000,
		PH_ACK_A   = 10'b0001000000,
		PH_RX_A    = 10'b0010000000,
		PH_ACK_B   = 10'b0100000000,
		PH_RX_B    = 10'b1000000000
	} phase_t;

endpackage
`default_nettype wire

>>> design/gsp_ctrl.sv
// poll sequencer: takes one accepted event word per cycle; emits results
`default_nettype none
module gsp_ctrl #(
	parameter int MAX_PAIRS = gsp_pkg::DEF_MAX_PAIRS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire gsp_pkg::in_word_t   in_word,
	input  wire logic                cfg_we,
	input  wire logic [7:0]          cfg_wdata,
	output gsp_pkg::res_bundle_t     res
);
	import gsp_pkg::*;

	localparam int PW = $clog2(MAX_PAIRS + 1);

	phase_t        phase_q, phase_d;
	logic          port_q, port_d;
	logic [PW-1:0] pairs_q, pairs_d;
	logic [5:0]    pos_q, pos_d;
	logic [7:0]    wait_q, wait_d;
	logic          latched_q, latched_d;
	logic [7:0]    timeout_q;
	logic [PW-1:0] pairs_dec;
	logic [3:0]    nib;

	function automatic out_word_t mk(input logic [1:0] act, input logic p,
			input logic [5:0] idx, input logic [7:0] data);
		out_word_t w;
		w.action    = act;
		w.sel_port  = p;
		w.buf_index = idx;
		w.data_byte = data;
		w.last      = 1'b0;
		return w;
	endfunction

	assign nib = in_word.rx_byte[3:0] & NIBBLE_MASK;
	assign pairs_dec = (pairs_q != '0) ? pairs_q - PW'(1) : '0;

	always_comb begin
		phase_d   = phase_q;
		port_d    = port_q;
		pairs_d   = pairs_q;
		pos_d     = pos_q;
		wait_d    = wait_q;
		latched_d = latched_q;
		res       = '0;
		if (accept) begin
			unique case (in_word.mode)
				MODE_START: begin
					if (phase_q == PH_IDLE) begin
						port_d      = in_word.port;
						pairs_d     = '0;
						pos_d       = IDX_FIRST;
						wait_d      = '0;
						res.word[0] = mk(ACT_STORE, in_word.port, IDX_STATUS, BYTE_BUSY);
						res.word[1] = mk(ACT_SEND, in_word.port, IDX_STATUS, BYTE_HDR);
						res.cnt     = 2'd2;
						latched_d   = 1'b0;
						phase_d     = PH_RX_HDR;
					end
				end
				MODE_TICK: begin
					if (phase_q == PH_ACK_HDR || phase_q == PH_ACK_ID ||
							phase_q == PH_ACK_A || phase_q == PH_ACK_B) begin
						if (wait_q == timeout_q) begin
							res.word[0] = mk(ACT_STORE, port_q, IDX_STATUS, BYTE_BUSY);
							res.word[1] = mk(ACT_ABORT, port_q, IDX_STATUS, 8'h00);
							res.cnt     = 2'd2;
							phase_d     = PH_IDLE;
							latched_d   = 1'b0;
						end else begin
							wait_d = wait_q + 8'd1;
						end
					end
				end
				MODE_ACK: begin
					unique case (phase_q)
						PH_ACK_HDR, PH_ACK_ID, PH_ACK_A, PH_ACK_B: begin
							res.word[0] = mk(ACT_SEND, port_q, IDX_STATUS,
								(phase_q == PH_ACK_HDR) ? BYTE_ID_REQ : BYTE_IDLE);
							res.cnt     = 2'd1;
							latched_d   = 1'b0;
							unique case (phase_q)
								PH_ACK_HDR: phase_d = PH_RX_ID;
								PH_ACK_ID:  phase_d = PH_RX_CHK;
								PH_ACK_A:   phase_d = PH_RX_A;
								default:    phase_d = PH_RX_B;
							endcase
						end
						PH_RX_A: begin
							// early acknowledge on the first byte of a pair
							res.word[0] = mk(ACT_STORE, port_q, IDX_STATUS, BYTE_BUSY);
							res.word[1] = mk(ACT_ABORT, port_q, IDX_STATUS, 8'h00);
							res.cnt     = 2'd2;
							phase_d     = PH_IDLE;
							latched_d   = 1'b0;
						end
						PH_RX_HDR, PH_RX_ID, PH_RX_CHK, PH_RX_B: latched_d = 1'b1;
						default: ;
					endcase
				end
				MODE_BYTE: begin
					unique case (phase_q)
						PH_RX_HDR: begin
							if (latched_q) begin
								res.word[0] = mk(ACT_SEND, port_q, IDX_STATUS, BYTE_ID_REQ);
								res.cnt     = 2'd1;
								latched_d   = 1'b0;
								phase_d     = PH_RX_ID;
							end else begin
								wait_d  = '0;
								phase_d = PH_ACK_HDR;
							end
						end
						PH_RX_ID: begin
							if (nib == 4'd0 || int'(nib) > MAX_PAIRS)
								pairs_d = PW'(MAX_PAIRS);
							else
								pairs_d = PW'(nib);
							res.word[0] = mk(ACT_STORE, port_q, IDX_ID, in_word.rx_byte);
							res.cnt     = 2'd1;
							if (latched_q) begin
								res.word[1] = mk(ACT_SEND, port_q, IDX_STATUS, BYTE_IDLE);
								res.cnt     = 2'd2;
								latched_d   = 1'b0;
								phase_d     = PH_RX_CHK;
							end else begin
								wait_d  = '0;
								phase_d = PH_ACK_ID;
							end
						end
						PH_RX_CHK: begin
							if (in_word.rx_byte != BYTE_CHK) begin
								res.word[0] = mk(ACT_STORE, port_q, IDX_STATUS, BYTE_BUSY);
								res.word[1] = mk(ACT_ABORT, port_q, IDX_STATUS, 8'h00);
								res.cnt     = 2'd2;
								phase_d     = PH_IDLE;
								latched_d   = 1'b0;
							end else if (latched_q) begin
								res.word[0] = mk(ACT_SEND, port_q, IDX_STATUS, BYTE_IDLE);
								res.cnt     = 2'd1;
								latched_d   = 1'b0;
								phase_d     = PH_RX_A;
							end else begin
								wait_d  = '0;
								phase_d = PH_ACK_A;
							end
						end
						PH_RX_A: begin
							res.word[0] = mk(ACT_STORE, port_q, pos_q, in_word.rx_byte);
							res.cnt     = 2'd1;
							pos_d       = pos_q + 6'd1;
							wait_d      = '0;
							phase_d     = PH_ACK_B;
						end
						PH_RX_B: begin
							res.word[0] = mk(ACT_STORE, port_q, pos_q, in_word.rx_byte);
							res.cnt     = 2'd1;
							pos_d       = pos_q + 6'd1;
							pairs_d     = pairs_dec;
							if (pairs_dec == '0) begin
								res.word[1] = mk(ACT_STORE, port_q, IDX_STATUS, 8'h00);
								res.word[2] = mk(ACT_DONE, port_q, IDX_STATUS, 8'h00);
								res.cnt     = 2'd3;
								phase_d     = PH_IDLE;
								latched_d   = 1'b0;
							end else if (latched_q) begin
								res.word[1] = mk(ACT_SEND, port_q, IDX_STATUS, BYTE_IDLE);
								res.cnt     = 2'd2;
								latched_d   = 1'b0;
								phase_d     = PH_RX_A;
							end else begin
								wait_d  = '0;
								phase_d = PH_ACK_A;
							end
						end
						default: ;
					endcase
				end
			endcase
		end
		unique case (res.cnt)
			2'd1:    res.word[0].last = 1'b1;
			2'd2:    res.word[1].last = 1'b1;
			2'd3:    res.word[2].last = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			port_q    <= 1'b0;
			pairs_q   <= '0;
			pos_q     <= '0;
			wait_q    <= '0;
			latched_q <= 1'b0;
			timeout_q <= TIMEOUT_RESET;
		end else begin
			phase_q   <= phase_d;
			port_q    <= port_d;
			pairs_q   <= pairs_d;
			pos_q     <= pos_d;
			wait_q    <= wait_d;
			latched_q <= latched_d;
			if (cfg_we) timeout_q <= cfg_wdata;
		end
	end

endmodule
`default_nettype wire

>>> design/gsp_res_fifo.sv
// result queue: takes up to three words a cycle, hands out one unless stalled
`default_nettype none
module gsp_res_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire gsp_pkg::res_bundle_t res,
	output logic                      full,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output gsp_pkg::out_word_t        out_word
);
	import gsp_pkg::*;

	localparam int AW = $clog2(RES_DEPTH);
	localparam int CW = $clog2(RES_DEPTH + 1);

	out_word_t     entry_q [RES_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic          pop;

	// room must remain for a full bundle of results
	assign full      = count_q > CW'(RES_DEPTH - RES_MAX);
	assign out_valid = count_q != '0;
	assign pop       = out_valid && !out_stall;
	assign out_word  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		for (int k = 0; k < RES_MAX; k++) begin
			if (CW'(k) < CW'(res.cnt))
				entry_q[wr_q + AW'(k)] <= res.word[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + AW'(res.cnt);
			rd_q    <= rd_q + AW'(pop);
			count_q <= count_q + CW'(res.cnt) - CW'(pop);
		end
	end

endmodule
`default_nettype wire

>>> design/gamepad_serial_poll_engine.sv
// top level of the gamepad serial poll engine
//
// channel   dir  payload      handshake
// in        in   in_word_t    in_valid / in_stall
// out       out  out_word_t   out_valid / out_stall
// cfg       in   timeout      cfg_we / cfg_wdata
//
// each event word is decoded by the sequencer in the cycle it is taken;
// its zero to three results land in an eight-word queue in that cycle
// and leave one word per cycle from the next cycle on, if not stalled
// one word per cycle while each event yields at most one result and the
// queue drains; a drain of one result per cycle paces events with more
// in_stall is high while fewer than three queue slots are free
// reset clears the sequencer, the queue pointers and loads timeout 80
`default_nettype none
module gamepad_serial_poll_engine #(
	parameter int MAX_PAIRS = gsp_pkg::DEF_MAX_PAIRS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire gsp_pkg::in_word_t  in_word,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output gsp_pkg::out_word_t      out_word,
	input  wire logic               cfg_we,
	input  wire logic [7:0]         cfg_wdata
);
	import gsp_pkg::*;

	res_bundle_t res;
	logic        accept;

	assign accept = in_valid && !in_stall;

	gsp_ctrl #(
		.MAX_PAIRS(MAX_PAIRS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_word  (in_word),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.res      (res)
	);

	gsp_res_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.full     (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

endmodule
`default_nettype wire
